FILE: sv/fdpi_pkg.sv
// Shared types and constants of the force decay point integrator.
package fdpi_pkg;

	// Register indexes of the configuration port
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_INVERSE_MASS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 1'b1;

	// Register reset values, 1.0 in Q16.16
	localparam logic [31:0] INVERSE_MASS_RST = 32'h0001_0000;
	localparam logic [30:0] SPEED_LIMIT_RST  = 31'h0001_0000;

	// Item modes
	localparam logic [1:0] MODE_ADD     = 2'd0;
	localparam logic [1:0] MODE_REPLACE = 2'd1;
	localparam logic [1:0] MODE_TICK    = 2'd2;

	// floor(y / 5) = (y * DIV5_RECIP) >> 34, exact for any 32-bit y
	localparam logic [31:0] DIV5_RECIP = 32'hCCCC_CCCD;

	// Iteration counts of the root and divide unit
	localparam int STEP_CNT_W = 6;
	localparam logic [STEP_CNT_W-1:0] SQRT_STEPS = 6'd32;
	localparam logic [STEP_CNT_W-1:0] DIV_STEPS  = 6'd31;

	typedef enum logic {
		RD_SQRT = 1'b0,
		RD_DIV  = 1'b1
	} rd_op_t;

	typedef struct packed {
		logic   start;
		rd_op_t op;
	} rd_req_t;

endpackage

FILE: sv/force_decay_point_integrator_2d.sv
// Top level of the 2D point integrator with decaying accumulated force.
//
// Input beats carry mode, vec_x, vec_y and time_step on in_valid / in_stall.
// Mode 0 adds vec to the force (saturated), mode 1 replaces it; both are
// taken while idle and give no result. Mode 3 is dropped.
// Mode 2 (tick) moves the position vec by the clamped, time-scaled speed
// along the acceleration direction and decays the force by 4/5. It gives
// one result beat on out_valid / out_stall: new_pos_x, new_pos_y and
// step_distance.
// In a tick one shared 32x32 multiplier runs nine products, a normalizing
// shift brings both axes into 31 bits, and the bit-serial root/divide
// unit forms a 32-bit root and a 31-bit quotient for each of the two
// direction divides.
// in_stall is high while a tick is at work, so no new beat is taken until
// the tick has ended; add and replace beats do not raise in_stall.
// A result waiting under out_stall does not block add or replace beats; a
// later tick holds in its last step until the output register is free.
// Reset clears the force to zero, sets inverse_mass and speed_limit to 1.0
// and empties the output register. Configuration writes go on cfg_we.
module force_decay_point_integrator_2d (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fdpi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     mode,
	input  logic signed [31:0]             vec_x,
	input  logic signed [31:0]             vec_y,
	input  logic [16:0]                    time_step,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [31:0]             new_pos_x,
	output logic signed [31:0]             new_pos_y,
	output logic [30:0]                    step_distance
);

	typedef enum logic [20:0] {
		ST_IDLE     = 21'h000001,
		ST_MUL_AX   = 21'h000002,
		ST_MUL_AY   = 21'h000004,
		ST_CAP_AY   = 21'h000008,
		ST_NORM     = 21'h000010,
		ST_SQ_X     = 21'h000020,
		ST_SQ_Y     = 21'h000040,
		ST_SQ_SUM   = 21'h000080,
		ST_ROOT     = 21'h000100,
		ST_DIST     = 21'h000200,
		ST_CAP_DIST = 21'h000400,
		ST_MUL_MX   = 21'h000800,
		ST_DIV_X    = 21'h001000,
		ST_WAIT_X   = 21'h002000,
		ST_MUL_MY   = 21'h004000,
		ST_DIV_Y    = 21'h008000,
		ST_WAIT_Y   = 21'h010000,
		ST_MUL_DX   = 21'h020000,
		ST_MUL_DY   = 21'h040000,
		ST_CAP_DY   = 21'h080000,
		ST_WRITE    = 21'h100000
	} state_t;

	state_t state_q;

	logic [31:0]        inverse_mass_q;
	logic [30:0]        speed_limit_q;
	logic signed [31:0] fx_q;
	logic signed [31:0] fy_q;
	logic               out_valid_q;
	logic signed [31:0] new_pos_x_q;
	logic signed [31:0] new_pos_y_q;
	logic [30:0]        step_distance_q;

	logic signed [31:0] pos_x_q;
	logic signed [31:0] pos_y_q;
	logic [16:0]        dt_q;
	logic [47:0]        sx_q;
	logic [47:0]        sy_q;
	logic               big_q;
	logic [63:0]        sum_q;
	logic [31:0]        len_q;
	logic [30:0]        dist_q;
	logic [30:0]        mx_q;
	logic [30:0]        my_q;
	logic [29:0]        cx_q;
	logic [29:0]        cy_q;
	logic [63:0]        prod_q;

	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [31:0]        fx_mag;
	logic [31:0]        fy_mag;
	logic [30:0]        speed;
	logic [30:0]        dist_d;
	logic [31:0]        dx_mag;
	logic [31:0]        dy_mag;
	logic signed [31:0] fx_decay;
	logic signed [31:0] fy_decay;
	logic signed [31:0] px_d;
	logic signed [31:0] py_d;
	logic signed [31:0] add_x;
	logic signed [31:0] add_y;
	logic               in_beat;
	logic               out_free;
	logic               norm_busy;

	fdpi_pkg::rd_req_t  rd_req;
	logic [63:0]        rd_opnd;
	logic [31:0]        rd_result;
	logic               rd_busy;

	// Clamp a 33-bit signed sum to 32 bits
	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Move a position by a magnitude with a sign, saturated
	function automatic logic signed [31:0] move(input logic signed [31:0] p,
		input logic neg, input logic [30:0] m);
		logic signed [32:0] d;
		d = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
		return sat33($signed({p[31], p}) + d);
	endfunction

	assign in_beat   = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign norm_busy = (sx_q[47:31] != '0) || (sy_q[47:31] != '0);

	assign fx_mag = fx_q[31] ? 32'(-fx_q) : 32'(fx_q);
	assign fy_mag = fy_q[31] ? 32'(-fy_q) : 32'(fy_q);

	// Clamp the length to the limit; any shifted vector exceeds it
	assign speed = big_q ? speed_limit_q
		: ((len_q < {1'b0, speed_limit_q}) ? len_q[30:0] : speed_limit_q);

	assign dist_d = (prod_q[63:47] != '0) ? 31'h7FFF_FFFF : prod_q[46:16];

	// Decay: floor(4a/5) = a - floor((a + 4) / 5)
	assign dx_mag   = fx_mag - {2'b00, cx_q};
	assign dy_mag   = fy_mag - {2'b00, cy_q};
	assign fx_decay = fx_q[31] ? -$signed(dx_mag) : $signed(dx_mag);
	assign fy_decay = fy_q[31] ? -$signed(dy_mag) : $signed(dy_mag);

	assign px_d  = move(pos_x_q, fx_q[31], mx_q);
	assign py_d  = move(pos_y_q, fy_q[31], my_q);
	assign add_x = sat33($signed({fx_q[31], fx_q}) + $signed({vec_x[31], vec_x}));
	assign add_y = sat33($signed({fy_q[31], fy_q}) + $signed({vec_y[31], vec_y}));

	// Pick the operands of the shared multiplier
	always_comb begin
		unique case (state_q)
			ST_MUL_AX: begin
				mul_a = fx_mag;
				mul_b = inverse_mass_q;
			end
			ST_MUL_AY: begin
				mul_a = fy_mag;
				mul_b = inverse_mass_q;
			end
			ST_SQ_X: begin
				mul_a = {1'b0, sx_q[30:0]};
				mul_b = {1'b0, sx_q[30:0]};
			end
			ST_SQ_Y: begin
				mul_a = {1'b0, sy_q[30:0]};
				mul_b = {1'b0, sy_q[30:0]};
			end
			ST_DIST: begin
				mul_a = {1'b0, speed};
				mul_b = {15'b0, dt_q};
			end
			ST_MUL_MX: begin
				mul_a = {1'b0, dist_q};
				mul_b = {1'b0, sx_q[30:0]};
			end
			ST_MUL_MY: begin
				mul_a = {1'b0, dist_q};
				mul_b = {1'b0, sy_q[30:0]};
			end
			ST_MUL_DX: begin
				mul_a = fx_mag + 32'd4;
				mul_b = fdpi_pkg::DIV5_RECIP;
			end
			ST_MUL_DY: begin
				mul_a = fy_mag + 32'd4;
				mul_b = fdpi_pkg::DIV5_RECIP;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Start the root with the sum of squares and the divides with the products
	always_comb begin
		rd_req.start = (state_q == ST_SQ_SUM) || (state_q == ST_DIV_X)
			|| (state_q == ST_DIV_Y);
		rd_req.op    = (state_q == ST_SQ_SUM) ? fdpi_pkg::RD_SQRT : fdpi_pkg::RD_DIV;
		rd_opnd      = (state_q == ST_SQ_SUM) ? (prod_q + sum_q) : prod_q;
	end

	fdpi_root_div u_root_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (rd_req),
		.opnd    (rd_opnd),
		.divisor (len_q),
		.result  (rd_result),
		.busy    (rd_busy)
	);

	// Sequencer, configuration, force state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			inverse_mass_q <= fdpi_pkg::INVERSE_MASS_RST;
			speed_limit_q  <= fdpi_pkg::SPEED_LIMIT_RST;
			fx_q           <= '0;
			fy_q           <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					fdpi_pkg::REG_INVERSE_MASS: inverse_mass_q <= cfg_data;
					fdpi_pkg::REG_SPEED_LIMIT:  speed_limit_q  <= cfg_data[30:0];
					default: ;
				endcase
			end
			// raise valid on a finished tick, drop it once the beat is taken
			if ((state_q == ST_WRITE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						case (mode)
							fdpi_pkg::MODE_ADD: begin
								fx_q <= add_x;
								fy_q <= add_y;
							end
							fdpi_pkg::MODE_REPLACE: begin
								fx_q <= vec_x;
								fy_q <= vec_y;
							end
							fdpi_pkg::MODE_TICK: state_q <= ST_MUL_AX;
							default: ;
						endcase
					end
				end
				ST_MUL_AX:   state_q <= ST_MUL_AY;
				ST_MUL_AY:   state_q <= ST_CAP_AY;
				ST_CAP_AY:   state_q <= ST_NORM;
				ST_NORM:     if (!norm_busy) state_q <= ST_SQ_X;
				ST_SQ_X:     state_q <= ST_SQ_Y;
				ST_SQ_Y:     state_q <= ST_SQ_SUM;
				ST_SQ_SUM:   state_q <= ST_ROOT;
				ST_ROOT:     if (!rd_busy) state_q <= ST_DIST;
				ST_DIST:     state_q <= ST_CAP_DIST;
				ST_CAP_DIST: state_q <= ST_MUL_MX;
				ST_MUL_MX:   state_q <= ST_DIV_X;
				ST_DIV_X:    state_q <= ST_WAIT_X;
				ST_WAIT_X:   if (!rd_busy) state_q <= ST_MUL_MY;
				ST_MUL_MY:   state_q <= ST_DIV_Y;
				ST_DIV_Y:    state_q <= ST_WAIT_Y;
				ST_WAIT_Y:   if (!rd_busy) state_q <= ST_MUL_DX;
				ST_MUL_DX:   state_q <= ST_MUL_DY;
				ST_MUL_DY:   state_q <= ST_CAP_DY;
				ST_CAP_DY:   state_q <= ST_WRITE;
				ST_WRITE: begin
					// hold until the output register can take the beat
					if (out_free) begin
						fx_q    <= fx_decay;
						fy_q    <= fy_decay;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the tick
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					pos_x_q <= vec_x;
					pos_y_q <= vec_y;
					dt_q    <= time_step;
					big_q   <= 1'b0;
				end
			end
			ST_MUL_AY: sx_q <= prod_q[63:16];
			ST_CAP_AY: sy_q <= prod_q[63:16];
			ST_NORM: begin
				// shift both axes together until each fits 31 bits
				if (norm_busy) begin
					sx_q  <= {1'b0, sx_q[47:1]};
					sy_q  <= {1'b0, sy_q[47:1]};
					big_q <= 1'b1;
				end
			end
			ST_SQ_Y:     sum_q  <= prod_q;
			ST_ROOT:     len_q  <= rd_result;
			ST_CAP_DIST: dist_q <= dist_d;
			ST_WAIT_X:   mx_q   <= (len_q == '0) ? '0 : rd_result[30:0];
			ST_WAIT_Y:   my_q   <= (len_q == '0) ? '0 : rd_result[30:0];
			ST_MUL_DY:   cx_q   <= prod_q[63:34];
			ST_CAP_DY:   cy_q   <= prod_q[63:34];
			ST_WRITE: begin
				if (out_free) begin
					new_pos_x_q     <= px_d;
					new_pos_y_q     <= py_d;
					step_distance_q <= dist_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign new_pos_x     = new_pos_x_q;
	assign new_pos_y     = new_pos_y_q;
	assign step_distance = step_distance_q;

	// The iterative unit is never left running between items
	a_root_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !rd_busy)
		else $error("root/divide unit busy while idle");

	// A result beat appears only from the final step of a tick
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_WRITE))
		else $error("result beat without a finished tick");

	// The move along the x axis never exceeds the step distance
	a_move_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_MY) |-> (mx_q <= dist_q))
		else $error("x move larger than step distance");

	// A pending step distance is not overwritten while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(step_distance))
		else $error("stalled result changed");

endmodule

FILE: sv/fdpi_root_div.sv
// Iterative unit: integer square root or division, one result bit per cycle.
module fdpi_root_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fdpi_pkg::rd_req_t    req,
	input  logic [63:0]          opnd,
	input  logic [31:0]          divisor,
	output logic [31:0]          result,
	output logic                 busy
);

	logic [fdpi_pkg::STEP_CNT_W-1:0] cnt_q;
	fdpi_pkg::rd_op_t                op_q;
	logic [34:0]                     acc_q;
	logic [63:0]                     work_q;
	logic [31:0]                     res_q;
	logic [31:0]                     div_q;

	logic [34:0] cand;
	logic [34:0] trial;
	logic [35:0] diff;
	logic        ge;

	// Form the partial remainder and the trial subtrahend of this step
	always_comb begin
		if (op_q == fdpi_pkg::RD_SQRT) begin
			cand  = {acc_q[32:0], work_q[63:62]};
			trial = {1'b0, res_q, 2'b01};
		end else begin
			cand  = {2'b00, acc_q[31:0], work_q[63]};
			trial = {3'b000, div_q};
		end
		diff = {1'b0, cand} - {1'b0, trial};
		ge   = ~diff[35];
	end

	// Count the steps and hold the operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			op_q  <= fdpi_pkg::RD_SQRT;
		end else if (req.start) begin
			op_q  <= req.op;
			cnt_q <= (req.op == fdpi_pkg::RD_SQRT) ? fdpi_pkg::SQRT_STEPS
				: fdpi_pkg::DIV_STEPS;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Load the operands, then shift one digit in each step
	always_ff @(posedge clk) begin
		if (req.start) begin
			res_q <= '0;
			div_q <= divisor;
			if (req.op == fdpi_pkg::RD_SQRT) begin
				acc_q  <= '0;
				work_q <= opnd;
			end else begin
				// quotient is known to fit 31 bits, so the top half starts as remainder
				acc_q  <= {4'b0000, opnd[61:31]};
				work_q <= {opnd[30:0], 33'b0};
			end
		end else if (cnt_q != '0) begin
			acc_q  <= ge ? diff[34:0] : cand;
			res_q  <= {res_q[30:0], ge};
			work_q <= (op_q == fdpi_pkg::RD_SQRT) ? {work_q[61:0], 2'b00}
				: {work_q[62:0], 1'b0};
		end
	end

	assign result = res_q;
	assign busy   = (cnt_q != '0);

endmodule
